// ===== hdl/sorted_min_stack_unit_defines.svh =====
// Assertion macros shared by the sorted min stack RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SORTED_MIN_STACK_UNIT_DEFINES_SVH
`define SORTED_MIN_STACK_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Implication check, sampled on the rising clock, off during reset.
`define SMS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted_min_stack_unit: check failed");
// Condition that must never be true.
`define SMS_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("sorted_min_stack_unit: forbidden condition seen");
`else
`define SMS_ASSERT(label, clk, rst, prop)
`define SMS_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== hdl/sms_pkg.sv =====
// Package for the sorted min stack: data width, depth default, codes.
// No dependencies.
`default_nettype none
package sms_pkg;
  localparam int DATA_W        = 32;
  localparam int DEFAULT_DEPTH = 16;

  // Request command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Top value reported for an empty store
  localparam logic signed [DATA_W-1:0] EMPTY_TOP = -32'sd1;
endpackage
`default_nettype wire

// ===== hdl/sms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/sorted_min_stack_unit.sv =====
// Sorted min stack: top level, sequencer and shared compare unit.
// Depends on sms_pkg, sms_ram and sorted_min_stack_unit_defines.svh.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// command selects push (push_value is inserted in order) or pop (the
// smallest value is removed; a pop on an empty store is ignored).
// Every request yields one result: done is high for exactly one cycle and
// top_value, is_empty and overflow are valid in that cycle. top_value is
// the smallest stored value, or -1 when the store is empty. A push into a
// full store is dropped and flagged with overflow.
// Values live in a RAM in descending order, so the smallest sits at the
// last used address. A push into an empty or full store and a pop leaving
// zero entries finish straight from idle; any other pop takes the new top
// (prefetched from RAM while idle) in ST_POPRD; any other push compares the
// stored values from the top down in ST_CMP, moving each one smaller than
// push_value up one address per cycle through the one RAM port pair and
// the one signed comparator, then stores it (in ST_PLACE if all were smaller).
// busy stays high until the done cycle, in which a new request may be taken.
// Reset empties the store. Results cannot be stalled.
`default_nettype none
`include "sorted_min_stack_unit_defines.svh"
module sorted_min_stack_unit
  import sms_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     command,
  input  wire logic signed [DATA_W-1:0] push_value,
  output logic                          done,
  output logic signed [DATA_W-1:0]      top_value,
  output logic                          is_empty,
  output logic                          overflow
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CMP   = 4'b0010,
    ST_PLACE = 4'b0100,
    ST_POPRD = 4'b1000
  } state_t;

  state_t                    state, state_next;
  logic [CW-1:0]             count, count_next;
  logic [AW-1:0]             idx, idx_next;
  logic signed [DATA_W-1:0]  val, val_next;
  logic signed [DATA_W-1:0]  top_reg, top_reg_next;
  logic                      done_next, is_empty_next, overflow_next;
  logic signed [DATA_W-1:0]  top_value_next;

  logic                      accept;
  logic [CW-1:0]             cnt_m1, cnt_m2;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [DATA_W-1:0]         ram_wdata, ram_rdata;
  logic signed [DATA_W-1:0]  rd_val;
  logic                      rd_less;

  sms_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign cnt_m1  = count - CW'(1);
  assign cnt_m2  = count - CW'(2);
  assign rd_val  = $signed(ram_rdata);
  // shared comparator: stored entry below the value being inserted
  assign rd_less = rd_val < val;

  // sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    val_next       = val;
    top_reg_next   = top_reg;
    done_next      = 1'b0;
    top_value_next = top_value;
    is_empty_next  = is_empty;
    overflow_next  = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = val;
    ram_raddr      = cnt_m1[AW-1:0];

    case (state)
      ST_IDLE: begin
        // prefetch the entry the request needs first
        ram_raddr = (command == CMD_POP) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
        if (accept) begin
          val_next = push_value;
          if (command == CMD_PUSH) begin
            if (count == CW'(DEPTH)) begin
              done_next      = 1'b1;
              overflow_next  = 1'b1;
              top_value_next = top_reg;
              is_empty_next  = 1'b0;
            end else if (count == '0) begin
              ram_we         = 1'b1;
              ram_waddr      = '0;
              ram_wdata      = push_value;
              count_next     = CW'(1);
              top_reg_next   = push_value;
              done_next      = 1'b1;
              top_value_next = push_value;
              is_empty_next  = 1'b0;
            end else begin
              idx_next   = cnt_m1[AW-1:0];
              state_next = ST_CMP;
            end
          end else begin
            if (count == '0) begin
              done_next      = 1'b1;
              top_value_next = EMPTY_TOP;
              is_empty_next  = 1'b1;
            end else if (count == CW'(1)) begin
              count_next     = '0;
              done_next      = 1'b1;
              top_value_next = EMPTY_TOP;
              is_empty_next  = 1'b1;
            end else begin
              count_next = cnt_m1;
              state_next = ST_POPRD;
            end
          end
        end
      end
      ST_CMP: begin
        // one entry per cycle: move it up or drop the value above it
        ram_we    = 1'b1;
        ram_waddr = idx + AW'(1);
        ram_raddr = idx - AW'(1);
        if (rd_less) begin
          ram_wdata = ram_rdata;
          if (idx == '0) begin
            state_next = ST_PLACE;
          end else begin
            idx_next = idx - AW'(1);
          end
        end else begin
          ram_wdata     = val;
          count_next    = count + CW'(1);
          done_next     = 1'b1;
          is_empty_next = 1'b0;
          state_next    = ST_IDLE;
          // lands above the old top slot: it is the new minimum
          if ((CW'(idx) + CW'(1)) == count) begin
            top_reg_next   = val;
            top_value_next = val;
          end else begin
            top_value_next = top_reg;
          end
        end
      end
      ST_PLACE: begin
        // every stored entry was smaller: value goes to the bottom
        ram_we         = 1'b1;
        ram_waddr      = '0;
        ram_wdata      = val;
        count_next     = count + CW'(1);
        done_next      = 1'b1;
        top_value_next = top_reg;
        is_empty_next  = 1'b0;
        state_next     = ST_IDLE;
      end
      ST_POPRD: begin
        // new top arrives from the prefetch
        top_reg_next   = rd_val;
        done_next      = 1'b1;
        top_value_next = rd_val;
        is_empty_next  = 1'b0;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      done     <= 1'b0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      done     <= done_next;
      overflow <= overflow_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    val       <= val_next;
    top_reg   <= top_reg_next;
    top_value <= top_value_next;
    is_empty  <= is_empty_next;
  end

  // checks
  `SMS_NEVER(a_done_while_busy, clk, rst, done && busy)
  `SMS_NEVER(a_count_range, clk, rst, count > CW'(DEPTH))
  `SMS_ASSERT(a_empty_top, clk, rst, (done && is_empty) |-> (top_value == EMPTY_TOP))
  `SMS_ASSERT(a_ovf_full, clk, rst, (done && overflow) |-> (count == CW'(DEPTH)))
  `SMS_ASSERT(a_full_push, clk, rst,
    (accept && (command == CMD_PUSH) && (count == CW'(DEPTH))) |=> (done && overflow))
endmodule
`default_nettype wire
